[design/nff_pkg.sv]
package nff_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;   // two's complement cell index, spans -1..24
    localparam int CNT_W   = 4;
    localparam int CMP_W   = 7;   // holds the largest buffer size
    localparam logic [CNT_W-1:0] MAX_LEN = 4'd10;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LOWA  = 7'h61;
    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_PLUS  = 7'h2b;
    localparam logic [3:0] NIB_MASK = 4'hf;
    localparam logic [3:0] DEC_BASE = 4'd10;
    localparam logic [VALUE_W-1:0] RECIP10 = 32'hcccccccd;
    localparam int RECIP10_SHIFT = 35;

    typedef enum logic [1:0] {
        KIND_UDEC  = 2'd0,
        KIND_ZDEC  = 2'd1,
        KIND_SDEC  = 2'd2,
        KIND_HEX   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         start_position;
        logic [3:0]         digit_count;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic       write_enable;
        logic [2:0] position;
        logic [6:0] character;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_ZERO,
        ST_DIGIT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic sign;
        logic zero;
        logic digit;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_kind;
        logic       cnt_zero;
        logic       cnt_one;
        logic       out_free;
    } t_sts;

    function automatic logic [6:0] nib_char(input logic [3:0] nib);
        logic [6:0] ch;
        if (nib < DEC_BASE) begin
            ch = CH_ZERO + 7'(nib);
        end else begin
            ch = CH_LOWA + 7'(nib - DEC_BASE);
        end
        return ch;
    endfunction

endpackage

[design/nff_ctrl.sv]
module nff_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  nff_pkg::t_sts i_sts,
    output nff_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    nff_pkg::t_state r_state;
    nff_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nff_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nff_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_sts.in_kind)
                        nff_pkg::KIND_SDEC: n_state = nff_pkg::ST_SIGN;
                        nff_pkg::KIND_UDEC: n_state = nff_pkg::ST_ZERO;
                        default:            n_state = nff_pkg::ST_DIGIT;
                    endcase
                end
            end
            nff_pkg::ST_SIGN: begin
                if (i_sts.out_free) n_state = nff_pkg::ST_ZERO;
            end
            nff_pkg::ST_ZERO: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.cnt_zero ? nff_pkg::ST_FLUSH : nff_pkg::ST_DIGIT;
                end
            end
            nff_pkg::ST_DIGIT: begin
                if (i_sts.out_free && i_sts.cnt_one) n_state = nff_pkg::ST_FLUSH;
            end
            nff_pkg::ST_FLUSH: begin
                if (i_sts.out_free) n_state = nff_pkg::ST_IDLE;
            end
            default: n_state = nff_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            nff_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            nff_pkg::ST_SIGN:  o_cmd.sign  = i_sts.out_free;
            nff_pkg::ST_ZERO:  o_cmd.zero  = i_sts.out_free;
            nff_pkg::ST_DIGIT: o_cmd.digit = i_sts.out_free;
            nff_pkg::ST_FLUSH: o_cmd.flush = i_sts.out_free;
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.sign, o_cmd.zero, o_cmd.digit, o_cmd.flush}))
        else $error("more than one datapath command at once");

    a_flush_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |=> (r_state == nff_pkg::ST_IDLE))
        else $error("flush did not end the item");

endmodule

[design/nff_dp.sv]
module nff_dp #(
    parameter int DISPLAY_CELLS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nff_pkg::t_in_item  i_in_data,
    input  nff_pkg::t_cmd      i_cmd,
    output nff_pkg::t_sts      o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output nff_pkg::t_out_item o_out_data
);

    localparam logic [nff_pkg::CMP_W-1:0] CELLS = nff_pkg::CMP_W'(DISPLAY_CELLS);

    logic [nff_pkg::VALUE_W-1:0] r_val;
    logic [nff_pkg::POS_W-1:0]   r_pos;
    logic [nff_pkg::CNT_W-1:0]   r_cnt;
    logic [3:0]                  r_start;
    logic                        r_neg;
    logic                        r_zeros;
    logic                        r_hex;
    nff_pkg::t_out_item          r_held;
    logic                        r_held_v;
    nff_pkg::t_out_item          r_out;
    logic                        r_out_v;

    logic [nff_pkg::CNT_W-1:0]   len_c;
    logic [nff_pkg::VALUE_W-1:0] mag;
    logic [2*nff_pkg::VALUE_W-1:0] prod;
    logic [nff_pkg::VALUE_W-1:0] quot;
    logic [nff_pkg::VALUE_W-1:0] rem_w;
    logic [3:0]                  dig;
    logic                        pos_ok;
    logic                        start_ok;
    logic                        cand_en;
    nff_pkg::t_out_item          cand;
    logic                        out_free;

    // divide by ten through the reciprocal, exact for all 32-bit values
    assign prod  = {{nff_pkg::VALUE_W{1'b0}}, r_val} *
                   {{nff_pkg::VALUE_W{1'b0}}, nff_pkg::RECIP10};
    assign quot  = nff_pkg::VALUE_W'(prod >> nff_pkg::RECIP10_SHIFT);
    assign rem_w = r_val - {quot[nff_pkg::VALUE_W-4:0], 3'b000}
                         - {quot[nff_pkg::VALUE_W-2:0], 1'b0};
    assign dig   = r_hex ? (r_val[3:0] & nff_pkg::NIB_MASK) : rem_w[3:0];

    assign len_c = (i_in_data.digit_count == '0) ? 4'd1 :
                   (i_in_data.digit_count > nff_pkg::MAX_LEN) ? nff_pkg::MAX_LEN :
                   i_in_data.digit_count;
    assign mag   = i_in_data.value[nff_pkg::VALUE_W-1] ? (~i_in_data.value + 32'd1) :
                   i_in_data.value;

    assign pos_ok   = !r_pos[nff_pkg::POS_W-1] &&
                      (nff_pkg::CMP_W'(r_pos[nff_pkg::POS_W-2:0]) < CELLS);
    assign start_ok = nff_pkg::CMP_W'(r_start) < CELLS;
    assign out_free = !r_out_v || !i_out_stall;

    always_comb begin
        cand         = '0;
        cand_en      = 1'b0;
        cand.write_enable = 1'b1;
        cand.position = r_pos[2:0];
        if (i_cmd.sign) begin
            cand_en        = start_ok;
            cand.position  = r_start[2:0];
            cand.character = r_neg ? nff_pkg::CH_MINUS : nff_pkg::CH_PLUS;
        end else if (i_cmd.zero) begin
            cand_en        = pos_ok;
            cand.character = nff_pkg::CH_ZERO;
        end else if (i_cmd.digit) begin
            // blank suppression in unpadded decimal modes: no write once the remaining value is zero
            cand_en        = pos_ok && (r_zeros || r_hex || (r_val != '0));
            cand.character = nff_pkg::nib_char(dig);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_in_data.start_position;
            r_pos   <= nff_pkg::POS_W'(i_in_data.start_position) +
                       nff_pkg::POS_W'(len_c) - 6'd1;
            r_zeros <= (i_in_data.kind == nff_pkg::KIND_ZDEC);
            r_hex   <= (i_in_data.kind == nff_pkg::KIND_HEX);
            r_neg   <= i_in_data.value[nff_pkg::VALUE_W-1];
            if (i_in_data.kind == nff_pkg::KIND_SDEC) begin
                r_val <= mag;
                r_cnt <= len_c - 4'd1;
            end else begin
                r_val <= i_in_data.value;
                r_cnt <= len_c;
            end
        end else if (i_cmd.digit) begin
            r_val <= r_hex ? (r_val >> 4) : quot;
            r_pos <= r_pos - 6'd1;
            r_cnt <= r_cnt - 4'd1;
        end
    end

    // one write is held back until we know whether it is the last
    always_ff @(posedge i_clk) begin
        if (cand_en) begin
            r_held <= cand;
        end
        if (i_cmd.flush) begin
            if (r_held_v) begin
                r_out <= '{write_enable: r_held.write_enable, position: r_held.position,
                           character: r_held.character, last: 1'b1};
            end else begin
                r_out <= '{write_enable: 1'b0, position: 3'd0, character: 7'd0,
                           last: 1'b1};
            end
        end else if (cand_en && r_held_v) begin
            r_out <= r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.flush) begin
                r_held_v <= 1'b0;
            end else if (cand_en) begin
                r_held_v <= 1'b1;
            end
            if (i_cmd.flush || (cand_en && r_held_v)) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_sts.in_kind  = i_in_data.kind;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_one  = (r_cnt == 4'd1);
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_v;
    assign o_out_data     = r_out;

    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_held_v)
        else $error("held write left over from previous item");

    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.write_enable) |-> r_out.last)
        else $error("terminator without last");

    a_flush_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_out_v && r_out.last && !r_held_v))
        else $error("flush did not present the final transfer");

endmodule

[design/numeric_field_formatter_unit.sv]
// Each accepted item runs one digit step per digit cell: a divide by ten, or a nibble shift in
// hex mode. Blank-suppressed and signed modes first write a forced '0' (signed after its sign).
// Each write is held back until the next one or the flush, which marks the final transfer last.
// Throughput: one item at a time; the next item is accepted once the last
// transfer is registered. Output stalls hold the digit loop.
// Reset: synchronous, active low; clears the controller, the held-write flag and output valid.
module numeric_field_formatter_unit #(
    parameter int DISPLAY_CELLS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nff_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nff_pkg::t_out_item o_out_data
);

    nff_pkg::t_cmd cmd;
    nff_pkg::t_sts sts;

    nff_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    nff_dp #(
        .DISPLAY_CELLS (DISPLAY_CELLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
